FILE: hdl/sfd_pkg.sv
// shared types and constants for the sensor frame deframer
package sfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned RawW    = 16;
  localparam int unsigned ScaledW = 28;

  // configuration register indexes
  localparam logic [1:0] RegHeader   = 2'd0;
  localparam logic [1:0] RegRateCode = 2'd1;
  localparam logic [1:0] RegYawCode  = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_BAD_TYPE = 2'd2
  } status_t;

  // completed frame handed from the collector to the decoder
  typedef struct packed {
    logic                   sum_ok;
    logic [ByteW-1:0]       frame_type;
    logic signed [RawW-1:0] raw;
  } frame_t;

endpackage

FILE: hdl/sensor_frame_deframer_core.sv
// top level of the sensor frame deframer: config registers and the two stages
//
// Input channel (in_valid/in_ready/in_rx_byte) takes one received serial byte
// per beat. Bytes are dropped until the header byte arrives; then a five-byte
// frame (header, type, data low, data high, checksum) is collected. A header
// byte inside a frame restarts it. Each completed frame gives one result beat
// on the output channel: status, channel, frame type, 16-bit measurement and the
// value in Q16 (rate: raw*4000, yaw: raw*360).
// Throughput: one byte per cycle while in_ready is high. A frame's result passes
// through the frame register, then the result register, before it can be taken.
// When the receiver stalls, the result register holds and the frame register
// absorbs one more completed frame; in_ready drops only when both are full.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 header byte,
// 1 rate type code, 2 yaw type code); other indexes are ignored. Write only
// while the block is idle.
// Reset (synchronous, rst_n low) returns to header hunting, empties both
// stages and loads header 0x5A, rate code 1 and yaw code 2.
module sensor_frame_deframer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_channel,
  output logic [7:0]         out_frame_type,
  output logic signed [15:0] out_meas_value,
  output logic signed [27:0] out_scaled_value_q16
);
  import sfd_pkg::*;

  localparam logic [ByteW-1:0] HeaderRst   = 8'h5A;
  localparam logic [ByteW-1:0] RateCodeRst = 8'h01;
  localparam logic [ByteW-1:0] YawCodeRst  = 8'h02;

  logic [ByteW-1:0] header_r;
  logic [ByteW-1:0] rate_code_r;
  logic [ByteW-1:0] yaw_code_r;
  logic             frm_valid;
  logic             frm_ready;
  frame_t           frm;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r    <= HeaderRst;
      rate_code_r <= RateCodeRst;
      yaw_code_r  <= YawCodeRst;
    end else if (cfg_we) begin
      case (cfg_index)
        RegHeader:   header_r    <= cfg_wdata;
        RegRateCode: rate_code_r <= cfg_wdata;
        RegYawCode:  yaw_code_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  sfd_collector u_collector (
    .clk         (clk),
    .rst_n       (rst_n),
    .header_byte (header_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .frm_valid   (frm_valid),
    .frm_ready   (frm_ready),
    .frm         (frm)
  );

  sfd_decode u_decode (
    .clk                  (clk),
    .rst_n                (rst_n),
    .rate_type_code       (rate_code_r),
    .yaw_type_code        (yaw_code_r),
    .frm_valid            (frm_valid),
    .frm_ready            (frm_ready),
    .frm                  (frm),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_channel          (out_channel),
    .out_frame_type       (out_frame_type),
    .out_meas_value       (out_meas_value),
    .out_scaled_value_q16 (out_scaled_value_q16)
  );

endmodule

FILE: hdl/sfd_collector.sv
// byte collector: header hunt, frame assembly and checksum check
module sfd_collector (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          header_byte,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  output logic                frm_valid,
  input  logic                frm_ready,
  output sfd_pkg::frame_t     frm
);
  import sfd_pkg::*;

  logic [2:0]       byte_count_r, byte_count_nxt;
  logic [ByteW-1:0] frame_bytes_r [4];
  logic             frm_valid_r, frm_valid_nxt;
  frame_t           frm_r;
  logic             accept;
  logic             hdr_hit;
  logic             complete;
  logic [ByteW-1:0] sum;

  // the frame stage takes a new frame when empty or being drained
  assign in_ready = !frm_valid_r || frm_ready;
  assign accept   = in_valid && in_ready;
  assign hdr_hit  = (in_rx_byte == header_byte);
  assign complete = accept && !hdr_hit && (byte_count_r == 3'd4);

  // 8-bit wrapping sum of header, type and data bytes
  assign sum = frame_bytes_r[0] + frame_bytes_r[1] + frame_bytes_r[2] + frame_bytes_r[3];

  // byte count: a header byte always restarts the frame
  always_comb begin
    byte_count_nxt = byte_count_r;
    if (accept) begin
      if (hdr_hit) begin
        byte_count_nxt = 3'd1;
      end else if (byte_count_r == 3'd4) begin
        byte_count_nxt = 3'd0;
      end else if (byte_count_r != 3'd0) begin
        byte_count_nxt = byte_count_r + 3'd1;
      end
    end
  end

  always_comb begin
    frm_valid_nxt = frm_valid_r;
    if (complete) begin
      frm_valid_nxt = 1'b1;
    end else if (frm_ready) begin
      frm_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 3'd0;
      frm_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      frm_valid_r  <= frm_valid_nxt;
    end
  end

  // frame byte store, written at the current position
  always_ff @(posedge clk) begin
    if (accept) begin
      if (hdr_hit) begin
        frame_bytes_r[0] <= in_rx_byte;
      end else if (byte_count_r != 3'd0 && byte_count_r != 3'd4) begin
        frame_bytes_r[byte_count_r[1:0]] <= in_rx_byte;
      end
    end
  end

  // completed frame record
  always_ff @(posedge clk) begin
    if (complete) begin
      frm_r.sum_ok     <= (sum == in_rx_byte);
      frm_r.frame_type <= frame_bytes_r[1];
      frm_r.raw        <= {frame_bytes_r[3], frame_bytes_r[2]};
    end
  end

  assign frm_valid = frm_valid_r;
  assign frm       = frm_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= 3'd4)
    else $error("byte count out of range");

  a_complete_loads: assert property (@(posedge clk) disable iff (!rst_n)
    complete |=> frm_valid_r)
    else $error("completed frame not held");

  a_hunt_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && byte_count_r == 3'd0 && !hdr_hit) |=> byte_count_r == 3'd0)
    else $error("non-header byte left hunt state");
`endif

endmodule

FILE: hdl/sfd_decode.sv
// frame decoder: type match, Q16 scaling and result register
module sfd_decode (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [7:0]                rate_type_code,
  input  logic [7:0]                yaw_type_code,
  input  logic                      frm_valid,
  output logic                      frm_ready,
  input  sfd_pkg::frame_t           frm,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic                      out_channel,
  output logic [7:0]                out_frame_type,
  output logic signed [15:0]        out_meas_value,
  output logic signed [27:0]        out_scaled_value_q16
);
  import sfd_pkg::*;

  // 2000/32768 and 180/32768 in Q16
  localparam logic signed [ScaledW-1:0] RateScale = 28'sd4000;
  localparam logic signed [ScaledW-1:0] YawScale  = 28'sd360;

  logic                      out_valid_r;
  status_t                   status_r, status_nxt;
  logic                      channel_r, channel_nxt;
  logic [ByteW-1:0]          type_r;
  logic signed [RawW-1:0]    raw_r, raw_nxt;
  logic signed [ScaledW-1:0] scaled_r, scaled_nxt;
  logic signed [ScaledW-1:0] raw_ext;
  logic signed [ScaledW-1:0] scale;
  logic signed [ScaledW-1:0] product;
  logic                      is_rate, is_yaw;
  logic                      load;

  assign frm_ready = !out_valid_r || out_ready;
  assign load      = frm_valid && frm_ready;

  // type match, rate wins when both codes are equal
  assign is_rate = (frm.frame_type == rate_type_code);
  assign is_yaw  = !is_rate && (frm.frame_type == yaw_type_code);

  // one shared multiplier for both scales
  assign raw_ext = ScaledW'(frm.raw);
  assign scale   = is_yaw ? YawScale : RateScale;
  assign product = raw_ext * scale;

  always_comb begin
    status_nxt  = ST_BAD_TYPE;
    channel_nxt = 1'b0;
    raw_nxt     = frm.raw;
    scaled_nxt  = '0;
    if (!frm.sum_ok) begin
      status_nxt = ST_BAD_SUM;
      raw_nxt    = '0;
    end else if (is_rate || is_yaw) begin
      status_nxt  = ST_OK;
      channel_nxt = is_yaw;
      scaled_nxt  = product;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frm_ready) begin
      out_valid_r <= frm_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      status_r  <= status_nxt;
      channel_r <= channel_nxt;
      type_r    <= frm.frame_type;
      raw_r     <= raw_nxt;
      scaled_r  <= scaled_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_channel          = channel_r;
  assign out_frame_type       = type_r;
  assign out_meas_value       = raw_r;
  assign out_scaled_value_q16 = scaled_r;

`ifndef SYNTH
  a_bad_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_BAD_SUM) |->
      (raw_r == '0 && scaled_r == '0 && !channel_r))
    else $error("checksum error result carries data");

  a_bad_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_BAD_TYPE) |-> (scaled_r == '0 && !channel_r))
    else $error("unknown type result carries scaled value");

  a_load_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("decoded frame not presented");
`endif

endmodule
